// ===== rtl/meter_lcd_packet_decoder_core_macros.svh =====
// Assertion macros used by the packet decoder top level.
`ifndef METER_LCD_PACKET_DECODER_CORE_MACROS_SVH
`define METER_LCD_PACKET_DECODER_CORE_MACROS_SVH
`ifndef NO_ASSERTIONS
// Checked property, masked while reset is high
`define MLPD_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("meter lcd decoder assertion failed");
// Checked property, also evaluated during reset
`define MLPD_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("meter lcd decoder assertion failed");
`else
`define MLPD_ASSERT(label, clk, rst, prop)
`define MLPD_ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

// ===== rtl/mlpd_pkg.sv =====
// Package: types, constants and segment tables of the LCD packet decoder.
`default_nettype none
package mlpd_pkg;

   // Packet framing
   localparam int PacketBytes = 18;
   localparam int KeptBytes   = PacketBytes - 1;
   localparam int CountWidth  = $clog2(PacketBytes);

   // Stream widths
   localparam int ReqDataWidth = 8;
   localparam int RspDataWidth = 56;
   localparam int RspUserWidth = 3;

   // Segment codes with special meaning
   localparam logic [10:0] SegMainOverflow = 11'h430;

   // Decimal exponents of the unit prefixes and point positions
   localparam logic signed [5:0] ExpNano  = -6'sd9;
   localparam logic signed [5:0] ExpMicro = -6'sd6;
   localparam logic signed [5:0] ExpMilli = -6'sd3;
   localparam logic signed [5:0] ExpKilo  = 6'sd3;
   localparam logic signed [5:0] ExpMega  = 6'sd6;
   localparam logic signed [5:0] ExpPt3   = -6'sd3;
   localparam logic signed [5:0] ExpPt2   = -6'sd2;
   localparam logic signed [5:0] ExpPt1   = -6'sd1;
   localparam logic signed [5:0] ExpNone  = 6'sd0;

   // Quantity codes
   localparam logic [2:0] QtyNone        = 3'd0;
   localparam logic [2:0] QtyVoltage     = 3'd1;
   localparam logic [2:0] QtyCurrent     = 3'd2;
   localparam logic [2:0] QtyResistance  = 3'd3;
   localparam logic [2:0] QtyFrequency   = 3'd4;
   localparam logic [2:0] QtyCapacitance = 3'd5;
   localparam logic [2:0] QtyContinuity  = 3'd6;

   typedef logic [PacketBytes-1:0][7:0] packet_type;

   typedef struct packed {
      logic       known;
      logic       overflow;
      logic [3:0] value;
   } digit_type;

   typedef struct packed {
      logic                  stage_valid;
      logic [CountWidth-1:0] byte_count;
   } cap_status_type;

   typedef struct packed {
      logic               packet_ok;
      logic               digit_error;
      logic               over_limit;
      logic signed [14:0] main_mantissa;
      logic signed [5:0]  main_exponent;
      logic [2:0]         quantity;
      logic [5:0]         measure_flags;
      logic [4:0]         status_flags;
      logic [13:0]        second_mantissa;
      logic signed [2:0]  second_exponent;
   } result_type;

   // Main display seven-segment code to digit; overflow and unknown read as 0
   function automatic digit_type seg_main(input logic [10:0] code);
      digit_type d;
      d = '{known: 1'b1, overflow: 1'b0, value: 4'd0};
      unique case (code)
         11'h000: d.value = 4'd0;
         SegMainOverflow: d.overflow = 1'b1;
         11'h533: d.value = 4'd0;
         11'h003: d.value = 4'd1;
         11'h721: d.value = 4'd2;
         11'h703: d.value = 4'd3;
         11'h213: d.value = 4'd4;
         11'h712: d.value = 4'd5;
         11'h732: d.value = 4'd6;
         11'h103: d.value = 4'd7;
         11'h733: d.value = 4'd8;
         11'h713: d.value = 4'd9;
         default: d.known = 1'b0;
      endcase
      return d;
   endfunction

   // Second display seven-segment code to digit; unknown reads as 0
   function automatic digit_type seg_second(input logic [6:0] code);
      digit_type d;
      d = '{known: 1'b1, overflow: 1'b0, value: 4'd0};
      unique case (code)
         7'h00: d.value = 4'd0;
         7'h7D: d.value = 4'd0;
         7'h05: d.value = 4'd1;
         7'h1B: d.value = 4'd2;
         7'h1F: d.value = 4'd3;
         7'h27: d.value = 4'd4;
         7'h3E: d.value = 4'd5;
         7'h7E: d.value = 4'd6;
         7'h15: d.value = 4'd7;
         7'h7F: d.value = 4'd8;
         7'h3F: d.value = 4'd9;
         default: d.known = 1'b0;
      endcase
      return d;
   endfunction

endpackage
`default_nettype wire

// ===== rtl/mlpd_capture.sv =====
// Byte capture: packet store, byte counter and the last-byte stage register.
`default_nettype none
module mlpd_capture (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   input  wire logic [7:0]                 req_byte,
   input  wire logic                       req_start,
   output logic                            req_ready,
   input  wire logic                       stage_take,
   output mlpd_pkg::cap_status_type        status,
   output mlpd_pkg::packet_type            packet
);

   logic [mlpd_pkg::CountWidth-1:0]           byte_count_ff, byte_count_in;
   logic [mlpd_pkg::KeptBytes-1:0][7:0]       store_ff, store_in;
   logic [7:0]                                last_byte_ff, last_byte_in;
   logic                                      stage_valid_ff, stage_valid_in;
   logic [mlpd_pkg::CountWidth-1:0]           idx;
   logic                                      is_last;
   logic                                      req_accept;

   // Stage is free when empty or moving on this cycle
   assign req_ready  = !stage_valid_ff || stage_take;
   assign req_accept = req_valid && req_ready;

   // Byte position: start flag forces position zero
   assign idx     = req_start ? '0 : byte_count_ff;
   assign is_last = idx >= mlpd_pkg::CountWidth'(mlpd_pkg::KeptBytes);

   // Next state of counter, stage and store
   always_comb begin
      byte_count_in  = byte_count_ff;
      last_byte_in   = last_byte_ff;
      stage_valid_in = stage_valid_ff && !stage_take;
      store_in       = store_ff;
      if (req_accept) begin
         if (is_last) begin
            byte_count_in  = '0;
            last_byte_in   = req_byte;
            stage_valid_in = 1'b1;
         end else begin
            byte_count_in = idx + mlpd_pkg::CountWidth'(1);
            for (int i = 0; i < mlpd_pkg::KeptBytes; i++) begin
               if (idx == mlpd_pkg::CountWidth'(i)) store_in[i] = req_byte;
            end
         end
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         byte_count_ff  <= '0;
         stage_valid_ff <= 1'b0;
      end else begin
         byte_count_ff  <= byte_count_in;
         stage_valid_ff <= stage_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      store_ff     <= store_in;
      last_byte_ff <= last_byte_in;
   end

   assign packet = {last_byte_ff, store_ff};
   assign status = '{stage_valid: stage_valid_ff, byte_count: byte_count_ff};

endmodule
`default_nettype wire

// ===== rtl/mlpd_decode.sv =====
// Packet decode: segment digits, exponent, quantity, flags and packet check.
`default_nettype none
module mlpd_decode (
   input  wire mlpd_pkg::packet_type  packet,
   output mlpd_pkg::result_type       result
);

   logic [3:0][10:0]           main_code;
   mlpd_pkg::digit_type [3:0]  main_dig;
   mlpd_pkg::digit_type [3:0]  sec_dig;
   logic [13:0]                main_value;
   logic [13:0]                sec_value;
   logic signed [14:0]         signed_value;
   logic signed [14:0]         main_mant;
   logic signed [5:0]          point_exp;
   logic signed [5:0]          exp_sum;
   logic signed [5:0]          main_exp;
   logic signed [2:0]          sec_exp;
   logic volt, ohm, amp, hz, farad, micro, nano, milli, kilo, mega;
   logic ac, dc, diode, beep, ovl;
   logic                       dig_err;
   logic                       pkt_ok;
   logic [5:0]                 mflags;
   logic [4:0]                 sflags;
   logic [2:0]                 qty;

   // Gather main segment codes from their scattered bits
   assign main_code[0] = {packet[3][2:0], 2'b00, packet[2][5:4], 2'b00, packet[3][5:4]};
   assign main_code[1] = {packet[4][6:4], 2'b00, packet[4][1:0], 2'b00, packet[5][1:0]};
   assign main_code[2] = {packet[6][2:0], 2'b00, packet[5][5:4], 2'b00, packet[6][5:4]};
   assign main_code[3] = {packet[7][6:4], 2'b00, packet[7][1:0], 2'b00, packet[8][1:0]};

   // Digit lookups; second display runs from byte 15 down to byte 12
   always_comb begin
      for (int i = 0; i < 4; i++) begin
         main_dig[i] = mlpd_pkg::seg_main(main_code[i]);
         sec_dig[i]  = mlpd_pkg::seg_second(packet[15-i][6:0]);
      end
   end

   // Decimal weighting of the digits
   assign main_value = 14'(main_dig[0].value) * 14'd1000 + 14'(main_dig[1].value) * 14'd100
                     + 14'(main_dig[2].value) * 14'd10 + 14'(main_dig[3].value);
   assign sec_value  = 14'(sec_dig[0].value) * 14'd1000
                     + 14'(sec_dig[1].value) * 14'd100
                     + 14'(sec_dig[2].value) * 14'd10
                     + 14'(sec_dig[3].value);

   // Minus sign on the main display
   assign signed_value = packet[0][2] ? -$signed({1'b0, main_value})
                                      : $signed({1'b0, main_value});

   // Flag bits
   assign volt  = packet[9][4];
   assign ohm   = packet[9][6];
   assign amp   = packet[10][0];
   assign hz    = packet[10][2];
   assign farad = packet[10][1];
   assign micro = farad ? packet[9][1] : packet[8][4];
   assign nano  = packet[8][5];
   assign milli = packet[9][0];
   assign kilo  = packet[9][2];
   assign mega  = packet[8][6];
   assign ac    = packet[1][4];
   assign dc    = packet[2][1];
   assign diode = packet[11][0];
   assign beep  = packet[11][1];
   assign ovl   = main_dig[2].overflow;

   // Main decimal point, leftmost wins
   always_comb begin
      priority if (packet[3][6]) point_exp = mlpd_pkg::ExpPt3;
      else if (packet[5][6])     point_exp = mlpd_pkg::ExpPt2;
      else if (packet[7][2])     point_exp = mlpd_pkg::ExpPt1;
      else                       point_exp = mlpd_pkg::ExpNone;
   end

   // Prefixes add up
   assign exp_sum = point_exp
                  + (nano  ? mlpd_pkg::ExpNano  : mlpd_pkg::ExpNone)
                  + (micro ? mlpd_pkg::ExpMicro : mlpd_pkg::ExpNone)
                  + (milli ? mlpd_pkg::ExpMilli : mlpd_pkg::ExpNone)
                  + (kilo  ? mlpd_pkg::ExpKilo  : mlpd_pkg::ExpNone)
                  + (mega  ? mlpd_pkg::ExpMega  : mlpd_pkg::ExpNone);

   // Quantity: later flags override earlier ones, diode reads as voltage
   always_comb begin
      qty = mlpd_pkg::QtyNone;
      if (volt)  qty = mlpd_pkg::QtyVoltage;
      if (amp)   qty = mlpd_pkg::QtyCurrent;
      if (ohm)   qty = mlpd_pkg::QtyResistance;
      if (hz)    qty = mlpd_pkg::QtyFrequency;
      if (farad) qty = mlpd_pkg::QtyCapacitance;
      if (beep)  qty = mlpd_pkg::QtyContinuity;
      if (diode) qty = mlpd_pkg::QtyVoltage;
   end

   // Mantissa: over limit clears, continuity shows exactly one
   always_comb begin
      priority if (ovl) main_mant = 15'sd0;
      else if (beep)    main_mant = 15'sd1;
      else              main_mant = signed_value;
   end
   assign main_exp = beep ? mlpd_pkg::ExpNone : exp_sum;

   // Second display point
   always_comb begin
      priority if (packet[14][7]) sec_exp = -3'sd3;
      else if (packet[13][7])     sec_exp = -3'sd2;
      else if (packet[12][7])     sec_exp = -3'sd1;
      else                        sec_exp = 3'sd0;
   end

   // Error mark
   assign dig_err = !(&{main_dig[0].known, main_dig[1].known, main_dig[2].known,
                        main_dig[3].known, sec_dig[0].known, sec_dig[1].known,
                        sec_dig[2].known, sec_dig[3].known})
                  || main_dig[0].overflow || main_dig[1].overflow
                  || main_dig[3].overflow;

   // Mode and status flags
   assign mflags = {packet[15][7], packet[16][3], diode, packet[16][4], dc || diode, ac};
   assign sflags = {packet[0][0], packet[16][1], packet[16][2], packet[1][0], packet[1][5]};

   // Packet consistency check
   assign pkt_ok = (packet[mlpd_pkg::KeptBytes] == 8'h00)
                 && $onehot0({nano, micro, milli, kilo, mega})
                 && $onehot0({hz, ohm, farad, amp, volt})
                 && !(ac && dc) && packet[1][1];

   // Result assembly
   assign result = '{packet_ok: pkt_ok, digit_error: dig_err, over_limit: ovl,
                     main_mantissa: main_mant, main_exponent: main_exp, quantity: qty,
                     measure_flags: mflags, status_flags: sflags,
                     second_mantissa: sec_value, second_exponent: sec_exp};

endmodule
`default_nettype wire

// ===== rtl/meter_lcd_packet_decoder_core.sv =====
// Top level of the multimeter LCD packet decoder.
//
//   channel | dir | tdata                        | tuser
//   req_    | in  | data_byte                    | packet_start
//   rsp_    | out | mantissas, exponents, flags  | packet_ok, digit_error, over_limit
//
// One byte is taken every cycle. The 18th byte of a packet is held in a stage
// register; its decode is combinational logic into the result register. Input
// stalls only while a decoded packet waits in the stage behind a full, stalled
// result register. Reset clears the byte count and the valid flags; the packet
// store is not cleared.
`default_nettype none
`include "meter_lcd_packet_decoder_core_macros.svh"
module meter_lcd_packet_decoder_core (
   input  wire logic                               clock,
   input  wire logic                               reset,
   // [7:0] data_byte
   input  wire logic [mlpd_pkg::ReqDataWidth-1:0]  req_tdata,
   // [0] packet_start
   input  wire logic                               req_tuser,
   input  wire logic                               req_tvalid,
   output logic                                    req_tready,
   // [14:0] main_mantissa, [20:15] main_exponent, [23:21] quantity,
   // [29:24] measure_flags, [34:30] status_flags, [48:35] second_mantissa,
   // [51:49] second_exponent, [55:52] zero
   output logic [mlpd_pkg::RspDataWidth-1:0]       rsp_tdata,
   // [0] packet_ok, [1] digit_error, [2] over_limit
   output logic [mlpd_pkg::RspUserWidth-1:0]       rsp_tuser,
   output logic                                    rsp_tvalid,
   input  wire logic                               rsp_tready
);

   // Byte count runs up to one past the last kept position
   localparam logic [mlpd_pkg::CountWidth-1:0] CountEnd =
      mlpd_pkg::CountWidth'(mlpd_pkg::PacketBytes);

   mlpd_pkg::cap_status_type  cap_status;
   mlpd_pkg::packet_type      packet;
   mlpd_pkg::result_type      decoded;
   mlpd_pkg::result_type      rsp_data_ff, rsp_data_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic                      stage_take;

   // Stage moves on when the result register is free or being drained
   assign stage_take = cap_status.stage_valid && (!rsp_valid_ff || rsp_tready);

   mlpd_capture u_capture (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_tvalid),
      .req_byte   (req_tdata),
      .req_start  (req_tuser),
      .req_ready  (req_tready),
      .stage_take (stage_take),
      .status     (cap_status),
      .packet     (packet)
   );

   mlpd_decode u_decode (
      .packet (packet),
      .result (decoded)
   );

   // Result register next state
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      if (stage_take) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = decoded;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   // Output packing
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = {rsp_data_ff.over_limit, rsp_data_ff.digit_error,
                        rsp_data_ff.packet_ok};
   assign rsp_tdata  = {4'b0000, rsp_data_ff.second_exponent, rsp_data_ff.second_mantissa,
                        rsp_data_ff.status_flags, rsp_data_ff.measure_flags,
                        rsp_data_ff.quantity, rsp_data_ff.main_exponent,
                        rsp_data_ff.main_mantissa};

   // Checks
   `MLPD_ASSERT(a_rsp_from_stage, clock, reset, $rose(rsp_tvalid) |-> $past(cap_status.stage_valid))
   `MLPD_ASSERT(a_hold_input, clock, reset, (cap_status.stage_valid && !stage_take) |-> !req_tready)
   `MLPD_ASSERT(a_count_range, clock, reset, cap_status.byte_count < CountEnd)
   `MLPD_ASSERT_ALWAYS(a_reset_clears, clock, reset |=> (!rsp_tvalid && !cap_status.stage_valid))

endmodule
`default_nettype wire

// ===== test/lcd_decode_check_pkg.sv =====
// Segment tables, packet decode and result checking for the LCD decoder testbench.
package lcd_decode_check_pkg;
   import mlpd_pkg::*;

   // Valid segment codes by digit value, index 0 is digit 0
   localparam logic [9:0][10:0] MainSegCodes = {
      11'h713, 11'h733, 11'h103, 11'h732, 11'h712,
      11'h213, 11'h703, 11'h721, 11'h003, 11'h533
   };
   localparam logic [9:0][6:0] SecondSegCodes = {
      7'h3F, 7'h7F, 7'h15, 7'h7E, 7'h3E,
      7'h27, 7'h1F, 7'h1B, 7'h05, 7'h7D
   };
   // Unlit digits read as zero
   localparam logic [10:0] SegMainBlank   = 11'h000;
   localparam logic [6:0]  SegSecondBlank = 7'h00;

   // Lookup outcomes besides a plain digit value
   localparam int DigitOverflow = 15;
   localparam int DigitUnknown  = -1;

   function automatic int main_digit_value(input logic [10:0] code);
      if (code == SegMainBlank) return 0;
      if (code == SegMainOverflow) return DigitOverflow;
      for (int d = 0; d < 10; d++) begin
         if (code == MainSegCodes[d]) return d;
      end
      return DigitUnknown;
   endfunction

   function automatic int second_digit_value(input logic [6:0] code);
      if (code == SegSecondBlank) return 0;
      for (int d = 0; d < 10; d++) begin
         if (code == SecondSegCodes[d]) return d;
      end
      return DigitUnknown;
   endfunction

   // Full decode of one 18-byte packet
   function automatic result_type decode_lcd_packet(input packet_type b);
      result_type       r;
      logic [3:0][10:0] code;
      int               digit, weight, mant, exp10, sexp;
      int unsigned      smant, prefixes, units;
      logic             err, ovl;
      logic             volt, ohm, amp, hz, farad, micro, nano, milli, kilo, mega;
      logic             autooff, link, ac, dc, autor, bat, mn, mx, rel, hold, diode, beep, ncv;
      logic [2:0]       qty;

      // segment bits gathered from their scattered byte positions
      code[0] = {b[3][2:0], 2'b00, b[2][5:4], 2'b00, b[3][5:4]};
      code[1] = {b[4][6:4], 2'b00, b[4][1:0], 2'b00, b[5][1:0]};
      code[2] = {b[6][2:0], 2'b00, b[5][5:4], 2'b00, b[6][5:4]};
      code[3] = {b[7][6:4], 2'b00, b[7][1:0], 2'b00, b[8][1:0]};

      err    = 1'b0;
      ovl    = 1'b0;
      mant   = 0;
      smant  = 0;
      weight = 1000;
      for (int i = 0; i < 4; i++) begin
         digit = main_digit_value(code[i]);
         if (digit == DigitOverflow) begin
            // only the third digit may legally show overflow
            if (i == 2) ovl = 1'b1;
            else err = 1'b1;
            digit = 0;
         end else if (digit == DigitUnknown) begin
            err   = 1'b1;
            digit = 0;
         end
         mant   += weight * digit;
         weight /= 10;
      end

      // second display, thousands digit in byte 15
      weight = 1000;
      for (int i = 0; i < 4; i++) begin
         digit = second_digit_value(b[15-i][6:0]);
         if (digit == DigitUnknown) begin
            err   = 1'b1;
            digit = 0;
         end
         smant  += weight * digit;
         weight /= 10;
      end

      // decimal points
      if (b[3][6]) exp10 = ExpPt3;
      else if (b[5][6]) exp10 = ExpPt2;
      else if (b[7][2]) exp10 = ExpPt1;
      else exp10 = ExpNone;

      if (b[14][7]) sexp = ExpPt3;
      else if (b[13][7]) sexp = ExpPt2;
      else if (b[12][7]) sexp = ExpPt1;
      else sexp = ExpNone;

      // annunciator bits
      volt    = b[9][4];
      ohm     = b[9][6];
      amp     = b[10][0];
      hz      = b[10][2];
      farad   = b[10][1];
      micro   = farad ? b[9][1] : b[8][4];
      nano    = b[8][5];
      milli   = b[9][0];
      kilo    = b[9][2];
      mega    = b[8][6];
      autooff = b[1][0];
      link    = b[1][1];
      ac      = b[1][4];
      bat     = b[1][5];
      dc      = b[2][1];
      autor   = b[16][4];
      mn      = b[16][2];
      mx      = b[16][1];
      hold    = b[16][3];
      rel     = b[15][7];
      diode   = b[11][0];
      beep    = b[11][1];
      ncv     = b[0][0];

      // prefixes stack when several are lit
      if (nano) exp10 += ExpNano;
      if (micro) exp10 += ExpMicro;
      if (milli) exp10 += ExpMilli;
      if (kilo) exp10 += ExpKilo;
      if (mega) exp10 += ExpMega;

      if (b[0][2]) mant = -mant;

      // later flags override earlier ones
      qty = QtyNone;
      if (volt) qty = QtyVoltage;
      if (amp) qty = QtyCurrent;
      if (ohm) qty = QtyResistance;
      if (hz) qty = QtyFrequency;
      if (farad) qty = QtyCapacitance;
      if (beep) begin
         qty   = QtyContinuity;
         mant  = 1;
         exp10 = ExpNone;
      end
      if (diode) qty = QtyVoltage;
      if (ovl) mant = 0;

      prefixes = int'(nano) + int'(micro) + int'(milli) + int'(kilo) + int'(mega);
      units    = int'(hz) + int'(ohm) + int'(farad) + int'(amp) + int'(volt);

      r.packet_ok = (b[KeptBytes] == 8'h00) && (prefixes <= 1) && (units <= 1)
                    && !(ac && dc) && link;
      r.digit_error     = err;
      r.over_limit      = ovl;
      r.main_mantissa   = mant[14:0];
      r.main_exponent   = exp10[5:0];
      r.quantity        = qty;
      r.measure_flags   = {rel, hold, diode, autor, dc | diode, ac};
      r.status_flags    = {ncv, mx, mn, autooff, bat};
      r.second_mantissa = smant[13:0];
      r.second_exponent = sexp[2:0];
      return r;
   endfunction

   // Tracks the byte position, predicts decodes and checks results in order
   class lcd_decode_scoreboard;
      packet_type  kept_bytes;
      int unsigned byte_index;
      result_type  decoded_q[$];
      int unsigned mismatches;

      function new();
         kept_bytes = '0;
         byte_index = 0;
         mismatches = 0;
      endfunction

      function void note_request(input logic [7:0] data_byte, input logic packet_start);
         int unsigned idx;
         packet_type  whole;
         idx = packet_start ? 0 : byte_index;
         if (idx >= KeptBytes) begin
            whole            = kept_bytes;
            whole[KeptBytes] = data_byte;
            decoded_q.push_back(decode_lcd_packet(whole));
            byte_index = 0;
         end else begin
            kept_bytes[idx] = data_byte;
            byte_index      = idx + 1;
         end
      endfunction

      function int unsigned pending();
         return decoded_q.size();
      endfunction

      function void compare_field(input string name, input logic signed [63:0] want,
                                  input logic signed [63:0] got, input longint stamp);
         if (want !== got) begin
            mismatches++;
            $display("%0d ns: %s mismatch, expected %0d, actual %0d", stamp, name, want, got);
         end
      endfunction

      function void check_result(input logic [RspDataWidth-1:0] tdata,
                                 input logic [RspUserWidth-1:0] tuser, input longint stamp);
         result_type want, got;
         if (decoded_q.size() == 0) begin
            mismatches++;
            $display("%0d ns: result with none expected, expected nothing, actual %h/%h",
                     stamp, tdata, tuser);
            return;
         end
         want = decoded_q.pop_front();
         got.packet_ok       = tuser[0];
         got.digit_error     = tuser[1];
         got.over_limit      = tuser[2];
         got.main_mantissa   = tdata[14:0];
         got.main_exponent   = tdata[20:15];
         got.quantity        = tdata[23:21];
         got.measure_flags   = tdata[29:24];
         got.status_flags    = tdata[34:30];
         got.second_mantissa = tdata[48:35];
         got.second_exponent = tdata[51:49];
         compare_field("packet_ok", want.packet_ok, got.packet_ok, stamp);
         compare_field("digit_error", want.digit_error, got.digit_error, stamp);
         compare_field("over_limit", want.over_limit, got.over_limit, stamp);
         compare_field("main_mantissa", want.main_mantissa, got.main_mantissa, stamp);
         compare_field("main_exponent", want.main_exponent, got.main_exponent, stamp);
         compare_field("quantity", want.quantity, got.quantity, stamp);
         compare_field("measure_flags", want.measure_flags, got.measure_flags, stamp);
         compare_field("status_flags", want.status_flags, got.status_flags, stamp);
         compare_field("second_mantissa", want.second_mantissa, got.second_mantissa, stamp);
         compare_field("second_exponent", want.second_exponent, got.second_exponent, stamp);
      endfunction
   endclass

endpackage

// ===== test/tb_top.sv =====
// Testbench top: drives byte streams into the LCD packet decoder and checks its results.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import mlpd_pkg::*;
   import lcd_decode_check_pkg::*;

   localparam int ResetCycles   = 10;
   localparam int RandomItems   = 2000;
   localparam int DrainCycles   = 8;
   localparam int WatchdogLimit = 2000;

   logic                    clock      = 1'b0;
   logic                    reset      = 1'b1;
   logic [ReqDataWidth-1:0] req_tdata  = '0;
   logic                    req_tuser  = 1'b0;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [RspDataWidth-1:0] rsp_tdata;
   logic [RspUserWidth-1:0] rsp_tuser;
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;

   int unsigned send_idle_pct = 0;
   int unsigned stall_pct     = 0;
   int unsigned items_sent    = 0;

   lcd_decode_scoreboard decoded_results;

   meter_lcd_packet_decoder_core u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready)
   );

   // 2 ns clock
   initial begin
      forever #1 clock = ~clock;
   end

   // receiver back-pressure
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(0, 99) >= stall_pct);
   end

   // observe both handshakes
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) decoded_results.note_request(req_tdata, req_tuser);
         if (rsp_tvalid && rsp_tready) decoded_results.check_result(rsp_tdata, rsp_tuser, $time);
      end
   end

   // no progress on either side for too long ends the run
   initial begin : watchdog
      int unsigned quiet;
      quiet = 0;
      while (quiet < WatchdogLimit) begin
         @(posedge clock);
         if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet = 0;
         else quiet++;
      end
      $display("Mismatches found");
      $finish;
   end

   // place a main digit code into its scattered bit positions
   function automatic packet_type put_main_code(input packet_type p, input int position,
                                                input logic [10:0] c);
      case (position)
         0: begin
            p[3][2:0] = c[10:8];
            p[2][5:4] = c[5:4];
            p[3][5:4] = c[1:0];
         end
         1: begin
            p[4][6:4] = c[10:8];
            p[4][1:0] = c[5:4];
            p[5][1:0] = c[1:0];
         end
         2: begin
            p[6][2:0] = c[10:8];
            p[5][5:4] = c[5:4];
            p[6][5:4] = c[1:0];
         end
         default: begin
            p[7][6:4] = c[10:8];
            p[7][1:0] = c[5:4];
            p[8][1:0] = c[1:0];
         end
      endcase
      return p;
   endfunction

   function automatic packet_type put_second_code(input packet_type p, input int position,
                                                  input logic [6:0] c);
      p[15-position][6:0] = c;
      return p;
   endfunction

   // mostly legal digits, with overflow, misplaced overflow and junk mixed in
   function automatic logic [10:0] pick_main_code(input int position);
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 6 && position == 2) return SegMainOverflow;
      if (r >= 6 && r < 8) return SegMainOverflow;
      if (r < 16) return 11'($urandom);
      if (r < 22) return SegMainBlank;
      return MainSegCodes[$urandom_range(0, 9)];
   endfunction

   function automatic logic [6:0] pick_second_code();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 8) return 7'($urandom);
      if (r < 14) return SegSecondBlank;
      return SecondSegCodes[$urandom_range(0, 9)];
   endfunction

   // random packet; most have a consistent flag set so packet_ok can pass
   function automatic packet_type build_packet();
      packet_type  p;
      logic [4:0]  prefix_sel;
      int unsigned qty_pick;
      for (int i = 0; i < PacketBytes; i++) p[i] = 8'($urandom);
      if ($urandom_range(0, 99) < 75) begin
         p[KeptBytes] = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'h00;
         p[8][6:4]    = 3'b000;
         p[9][2:0]    = 3'b000;
         p[9][4]      = 1'b0;
         p[9][6]      = 1'b0;
         p[10][2:0]   = 3'b000;
         p[11][0]     = ($urandom_range(0, 9) == 0);
         p[11][1]     = ($urandom_range(0, 9) == 0);
         qty_pick     = $urandom_range(QtyNone, QtyCapacitance);
         case (qty_pick)
            QtyVoltage:     p[9][4]  = 1'b1;
            QtyCurrent:     p[10][0] = 1'b1;
            QtyResistance:  p[9][6]  = 1'b1;
            QtyFrequency:   p[10][2] = 1'b1;
            QtyCapacitance: p[10][1] = 1'b1;
            default: ;
         endcase
         // one prefix or none, sometimes an arbitrary mix
         prefix_sel = ($urandom_range(0, 5) == 0) ? 5'($urandom)
                                                  : 5'(6'b1 << $urandom_range(0, 5));
         p[8][5] = prefix_sel[0];
         if (p[10][1]) p[9][1] = prefix_sel[1];
         else p[8][4] = prefix_sel[1];
         p[9][0] = prefix_sel[2];
         p[9][2] = prefix_sel[3];
         p[8][6] = prefix_sel[4];
         p[1][4] = ($urandom_range(0, 1) != 0);
         p[2][1] = p[1][4] ? ($urandom_range(0, 7) == 0) : ($urandom_range(0, 1) != 0);
         p[1][1] = ($urandom_range(0, 15) != 0);
      end
      for (int pos = 0; pos < 4; pos++) begin
         p = put_main_code(p, pos, pick_main_code(pos));
         p = put_second_code(p, pos, pick_second_code());
      end
      return p;
   endfunction

   // one request, with random idle cycles before it
   task automatic send_request(input logic [7:0] data_byte, input logic packet_start);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= data_byte;
      req_tuser  <= packet_start;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      items_sent++;
   endtask

   task automatic send_packet(input packet_type p, input int count, input logic with_start);
      for (int i = 0; i < count; i++) send_request(p[i], with_start && (i == 0));
   endtask

   initial begin : stimulus
      packet_type  p;
      int unsigned target, r, noise_len;
      decoded_results = new();
      repeat (ResetCycles) @(posedge clock);
      reset <= 1'b0;

      // directed: -9999 at the lowest exponent, every status and mode flag lit, 9999 on second display
      p = '0;
      for (int i = 0; i < 4; i++) begin
         p = put_main_code(p, i, MainSegCodes[9]);
         p = put_second_code(p, i, SecondSegCodes[9]);
      end
      p[0][2]    = 1'b1;   // minus
      p[0][0]    = 1'b1;   // noncontact
      p[1]       = 8'h33;  // auto-off, link, ac, low battery
      p[3][6]    = 1'b1;   // point before last three digits
      p[8][5]    = 1'b1;   // nano
      p[8][4]    = 1'b1;   // micro
      p[9][0]    = 1'b1;   // milli
      p[9][4]    = 1'b1;   // volt
      p[11][0]   = 1'b1;   // diode
      p[14][7]   = 1'b1;   // second display point
      p[15][7]   = 1'b1;   // relative
      p[16][4:1] = 4'hF;   // autorange, hold, min, max
      send_packet(p, PacketBytes, 1'b1);
      // a packet cut short by the next start
      send_packet(build_packet(), 6, 1'b1);

      // random traffic in four idling phases
      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin
               send_idle_pct = 0;
               stall_pct     = 0;
            end
            1: begin
               send_idle_pct = 46;
               stall_pct     = 0;
            end
            2: begin
               send_idle_pct = 0;
               stall_pct     = 46;
            end
            default: begin
               send_idle_pct = 30;
               stall_pct     = 30;
            end
         endcase
         target = items_sent + RandomItems / 4;
         while (items_sent < target) begin
            r = $urandom_range(0, 99);
            if (r < 78) begin
               send_packet(build_packet(), PacketBytes, 1'b1);
            end else if (r < 84) begin
               // relies on the running byte count
               send_packet(build_packet(), PacketBytes, 1'b0);
            end else if (r < 92) begin
               send_packet(build_packet(), $urandom_range(1, KeptBytes), 1'b1);
            end else begin
               noise_len = $urandom_range(1, 24);
               for (int i = 0; i < noise_len; i++)
                  send_request(8'($urandom), $urandom_range(0, 7) == 0);
            end
         end
      end
      req_tvalid <= 1'b0;

      // drain
      while (decoded_results.pending() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
      if (decoded_results.mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

// ===== meter_lcd_packet_decoder_core.f =====
+incdir+rtl
rtl/mlpd_pkg.sv
rtl/mlpd_capture.sv
rtl/mlpd_decode.sv
rtl/meter_lcd_packet_decoder_core.sv
test/lcd_decode_check_pkg.sv
test/tb_top.sv
